// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the blend unit RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/rbu_pkg.sv -----
// Package for the RGBA blend unit: widths, factor and equation codes,
// register indexes and shared types. No dependencies.
`default_nettype none

package rbu_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned TERM_W   = 16;
  localparam int unsigned FACT_W   = 4;
  localparam int unsigned EQ_W     = 3;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [TERM_W-1:0] TERM_MAX   = 16'd65025;
  localparam logic [TERM_W-1:0] ROUND_HALF = 16'd127;

  // Blend factor codes
  localparam logic [FACT_W-1:0] FACT_ZERO         = 4'd0;
  localparam logic [FACT_W-1:0] FACT_ONE          = 4'd1;
  localparam logic [FACT_W-1:0] FACT_SRC_COLOR    = 4'd2;
  localparam logic [FACT_W-1:0] FACT_INV_SRC_COLOR = 4'd3;
  localparam logic [FACT_W-1:0] FACT_SRC_ALPHA    = 4'd4;
  localparam logic [FACT_W-1:0] FACT_INV_SRC_ALPHA = 4'd5;
  localparam logic [FACT_W-1:0] FACT_DST_ALPHA    = 4'd6;
  localparam logic [FACT_W-1:0] FACT_INV_DST_ALPHA = 4'd7;
  localparam logic [FACT_W-1:0] FACT_DST_COLOR    = 4'd8;
  localparam logic [FACT_W-1:0] FACT_INV_DST_COLOR = 4'd9;

  // Blend equation codes
  localparam logic [EQ_W-1:0] EQ_ADD     = 3'd0;
  localparam logic [EQ_W-1:0] EQ_SUB     = 3'd1;
  localparam logic [EQ_W-1:0] EQ_REV_SUB = 3'd2;
  localparam logic [EQ_W-1:0] EQ_MIN     = 3'd3;
  localparam logic [EQ_W-1:0] EQ_MAX     = 3'd4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SRC_FACTOR = 2'd0;
  localparam logic [1:0] REG_DST_FACTOR = 2'd1;
  localparam logic [1:0] REG_EQUATION   = 2'd2;

  // Reset values
  localparam logic [FACT_W-1:0] SRC_FACTOR_RST = FACT_ONE;
  localparam logic [FACT_W-1:0] DST_FACTOR_RST = FACT_ZERO;
  localparam logic [EQ_W-1:0]   EQUATION_RST   = EQ_ADD;

  typedef struct packed {
    logic [FACT_W-1:0] src_factor;
    logic [FACT_W-1:0] dst_factor;
    logic [EQ_W-1:0]   equation;
  } rbu_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rbu_pixel_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rbu_ifs.sv -----
// Valid/ready stream interfaces for the blend unit: source/destination
// pixel word in, blended pixel word out. Depends on rbu_pkg.
`default_nettype none

interface rbu_in_if import rbu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] src_red;
  logic [CHAN_W-1:0] src_green;
  logic [CHAN_W-1:0] src_blue;
  logic [CHAN_W-1:0] src_alpha;
  logic [CHAN_W-1:0] dst_red;
  logic [CHAN_W-1:0] dst_green;
  logic [CHAN_W-1:0] dst_blue;
  logic [CHAN_W-1:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface rbu_out_if import rbu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/rbu_regs.sv -----
// APB-style configuration registers of the blend unit.
// Depends on rbu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbu_regs import rbu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output rbu_cfg_t                cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;
  rbu_cfg_t   cfg_r;
  rbu_cfg_t   cfg_nxt;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Decode the write; other indexes drop the word
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SRC_FACTOR: cfg_nxt.src_factor = pwdata[FACT_W-1:0];
        REG_DST_FACTOR: cfg_nxt.dst_factor = pwdata[FACT_W-1:0];
        REG_EQUATION:   cfg_nxt.equation   = pwdata[EQ_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_factor <= SRC_FACTOR_RST;
      cfg_r.dst_factor <= DST_FACTOR_RST;
      cfg_r.equation   <= EQUATION_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_SRC_FACTOR: prdata = {{(PDATA_W-FACT_W){1'b0}}, cfg_r.src_factor};
      REG_DST_FACTOR: prdata = {{(PDATA_W-FACT_W){1'b0}}, cfg_r.dst_factor};
      REG_EQUATION:   prdata = {{(PDATA_W-EQ_W){1'b0}}, cfg_r.equation};
      default:        prdata = '0;
    endcase
  end

  `ASSERT_RST(a_eq_write, clk, rst_n, wr_en && (reg_idx == REG_EQUATION) |=> cfg_r.equation == $past(pwdata[EQ_W-1:0]), "equation write lost")

endmodule

`default_nettype wire

// ----- hw/rtl/rbu_channel.sv -----
// One color channel of the blender: factor select, two 8x8 products,
// equation, clamp and round to 8 bits. Depends on rbu_pkg.
`default_nettype none

module rbu_channel import rbu_pkg::*; (
  input  wire rbu_cfg_t           cfg,
  input  wire logic [CHAN_W-1:0]  sc,
  input  wire logic [CHAN_W-1:0]  sa,
  input  wire logic [CHAN_W-1:0]  dc,
  input  wire logic [CHAN_W-1:0]  da,
  output logic      [CHAN_W-1:0]  res
);

  logic [CHAN_W-1:0] s_fact;
  logic [CHAN_W-1:0] d_fact;
  logic [TERM_W-1:0] s_term;
  logic [TERM_W-1:0] d_term;
  logic [TERM_W+1:0] sum_w;
  logic [TERM_W+1:0] diff_sd;
  logic [TERM_W+1:0] diff_ds;
  logic [TERM_W+1:0] comb;
  logic [TERM_W-1:0] clamped;
  logic [TERM_W:0]   biased;
  logic [TERM_W:0]   quot_sum;

  function automatic logic [CHAN_W-1:0] factor_value(
    input logic [FACT_W-1:0] code,
    input logic [CHAN_W-1:0] c_sc,
    input logic [CHAN_W-1:0] c_sa,
    input logic [CHAN_W-1:0] c_dc,
    input logic [CHAN_W-1:0] c_da
  );
    logic [CHAN_W-1:0] f;
    case (code)
      FACT_ZERO:          f = '0;
      FACT_ONE:           f = FULL_SCALE;
      FACT_SRC_COLOR:     f = c_sc;
      FACT_INV_SRC_COLOR: f = FULL_SCALE - c_sc;
      FACT_SRC_ALPHA:     f = c_sa;
      FACT_INV_SRC_ALPHA: f = FULL_SCALE - c_sa;
      FACT_DST_ALPHA:     f = c_da;
      FACT_INV_DST_ALPHA: f = FULL_SCALE - c_da;
      FACT_DST_COLOR:     f = c_dc;
      FACT_INV_DST_COLOR: f = FULL_SCALE - c_dc;
      default:            f = FULL_SCALE;
    endcase
    return f;
  endfunction

  // Pick factors and form the two terms (units of 1/65025)
  assign s_fact = factor_value(cfg.src_factor, sc, sa, dc, da);
  assign d_fact = factor_value(cfg.dst_factor, sc, sa, dc, da);
  assign s_term = sc * s_fact;
  assign d_term = dc * d_fact;

  // Combine; two's complement, top bit is the sign
  assign sum_w   = {2'b00, s_term} + {2'b00, d_term};
  assign diff_sd = {2'b00, s_term} - {2'b00, d_term};
  assign diff_ds = {2'b00, d_term} - {2'b00, s_term};

  always_comb begin
    case (cfg.equation)
      EQ_SUB:     comb = diff_sd;
      EQ_REV_SUB: comb = diff_ds;
      EQ_MIN:     comb = (s_term < d_term) ? {2'b00, s_term} : {2'b00, d_term};
      EQ_MAX:     comb = (s_term > d_term) ? {2'b00, s_term} : {2'b00, d_term};
      default:    comb = sum_w;
    endcase
  end

  // Clamp to 0..65025
  always_comb begin
    if (comb[TERM_W+1]) begin
      clamped = '0;
    end else if (comb[TERM_W:0] > {1'b0, TERM_MAX}) begin
      clamped = TERM_MAX;
    end else begin
      clamped = comb[TERM_W-1:0];
    end
  end

  // Round: floor((t+127)/255) as (x + (x>>8) + 1) >> 8, exact over this range
  assign biased   = {1'b0, clamped} + {1'b0, ROUND_HALF};
  assign quot_sum = biased + {8'd0, biased[TERM_W:8]} + {{TERM_W{1'b0}}, 1'b1};
  assign res      = quot_sum[TERM_W-1:8];

endmodule

`default_nettype wire

// ----- hw/rtl/rgba_blend_unit.sv -----
// Top level of the RGBA8 blend unit: input word register, four channel
// blenders, result register. Depends on rbu_pkg, rbu_ifs, rbu_regs, rbu_channel.
//
//   port      dir  handshake          carries
//   in_ch     in   valid/ready        source and destination RGBA8 pixel
//   out_ch    out  valid/ready        blended RGBA8 pixel
//   psel..    in   APB write/read     source factor, dest factor, equation select
//
// One word is accepted per cycle while out_ch is not stalled; its result passes
// through the input register, then the result register, before it is offered on out_ch.
// Reset clears both valid flags and loads the register defaults.
// A stalled result holds in the result register; the input register keeps
// taking one more word, after which in_ch.ready follows out_ch.ready.
`default_nettype none
`include "assert_macros.svh"

module rgba_blend_unit import rbu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  rbu_in_if.sink                  in_ch,
  rbu_out_if.source               out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  rbu_cfg_t   cfg;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  rbu_pixel_t src_r;
  rbu_pixel_t dst_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  rbu_pixel_t res_r;
  rbu_pixel_t res_nxt;
  logic       out_free;
  logic       in_acc;
  logic       s1_adv;

  rbu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake control
  assign out_free      = !out_valid_r || out_ch.ready;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_ch.ready   = !s1_valid_r || out_free;
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt  = in_acc || (s1_valid_r && !out_free);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      src_r <= '{red: in_ch.src_red, green: in_ch.src_green,
                 blue: in_ch.src_blue, alpha: in_ch.src_alpha};
      dst_r <= '{red: in_ch.dst_red, green: in_ch.dst_green,
                 blue: in_ch.dst_blue, alpha: in_ch.dst_alpha};
    end
  end

  // Blend each channel; alpha uses the alphas as its colors
  rbu_channel u_red (
    .cfg (cfg), .sc (src_r.red), .sa (src_r.alpha),
    .dc (dst_r.red), .da (dst_r.alpha), .res (res_nxt.red)
  );
  rbu_channel u_green (
    .cfg (cfg), .sc (src_r.green), .sa (src_r.alpha),
    .dc (dst_r.green), .da (dst_r.alpha), .res (res_nxt.green)
  );
  rbu_channel u_blue (
    .cfg (cfg), .sc (src_r.blue), .sa (src_r.alpha),
    .dc (dst_r.blue), .da (dst_r.alpha), .res (res_nxt.blue)
  );
  rbu_channel u_alpha (
    .cfg (cfg), .sc (src_r.alpha), .sa (src_r.alpha),
    .dc (dst_r.alpha), .da (dst_r.alpha), .res (res_nxt.alpha)
  );

  // Load the result register when the input stage advances
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = res_r.red;
  assign out_ch.out_green = res_r.green;
  assign out_ch.out_blue  = res_r.blue;
  assign out_ch.out_alpha = res_r.alpha;

  `ASSERT_RST(a_in_to_s1, clk, rst_n, in_acc |=> s1_valid_r, "accepted word not held in input stage")
  `ASSERT_RST(a_s1_to_out, clk, rst_n, s1_adv |=> out_valid_r, "advanced word missing from result register")
  `ASSERT_RST(a_s1_hold, clk, rst_n, s1_valid_r && !out_free |=> s1_valid_r && $stable(src_r) && $stable(dst_r), "blocked input stage lost its word")
  `ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid_r && !s1_valid_r, "valid flags not cleared by reset")

endmodule

`default_nettype wire

// ----- sim/rgba_blend_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgba_blend_unit: drives pixel words under many
// blend settings and checks every blended word against an internal predictor.
// Depends on rbu_pkg, rbu_ifs and the rgba_blend_unit RTL.

module rgba_blend_unit_tb import rbu_pkg::*; ();

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 6;
  localparam int STUCK_LIMIT  = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int DIRECTED_RUNS = 3;
  localparam int RANDOM_RUNS  = 24;
  localparam int RANDOM_WORDS = 26;
  localparam int HOLD_RUN     = 6;

  // Index past the register map; writes there must be ignored
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  localparam int SCALE      = FULL_SCALE;
  localparam int TERM_LIMIT = TERM_MAX;
  localparam int HALF_STEP  = ROUND_HALF;

  typedef struct packed {
    rbu_pixel_t src;
    rbu_pixel_t dst;
  } blend_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic        drv_valid = 1'b0;
  blend_word_t drv_word = '0;
  logic        sink_ready = 1'b0;
  logic        in_taken = 1'b0;

  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int error_count = 0;

  rbu_cfg_t    blend_cfg = '{src_factor: SRC_FACTOR_RST, dst_factor: DST_FACTOR_RST,
                             equation: EQUATION_RST};
  blend_word_t pending_words[$];
  rbu_pixel_t  blended_pixels[$];

  rbu_in_if  in_ch ();
  rbu_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.src_red   = drv_word.src.red;
  assign in_ch.src_green = drv_word.src.green;
  assign in_ch.src_blue  = drv_word.src.blue;
  assign in_ch.src_alpha = drv_word.src.alpha;
  assign in_ch.dst_red   = drv_word.dst.red;
  assign in_ch.dst_green = drv_word.dst.green;
  assign in_ch.dst_blue  = drv_word.dst.blue;
  assign in_ch.dst_alpha = drv_word.dst.alpha;
  assign out_ch.ready    = sink_ready;

  rgba_blend_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Factor in units of 1/255; unknown codes weigh as one
  function automatic int factor_weight(logic [FACT_W-1:0] code, int sc, int sa,
                                       int dc, int da);
    case (code)
      FACT_ZERO:          return 0;
      FACT_ONE:           return SCALE;
      FACT_SRC_COLOR:     return sc;
      FACT_INV_SRC_COLOR: return SCALE - sc;
      FACT_SRC_ALPHA:     return sa;
      FACT_INV_SRC_ALPHA: return SCALE - sa;
      FACT_DST_ALPHA:     return da;
      FACT_INV_DST_ALPHA: return SCALE - da;
      FACT_DST_COLOR:     return dc;
      FACT_INV_DST_COLOR: return SCALE - dc;
      default:            return SCALE;
    endcase
  endfunction

  // Combine both terms, clamp to the unit range and round to 8 bits
  function automatic logic [CHAN_W-1:0] mix_channel(rbu_cfg_t c, int sc, int sa,
                                                    int dc, int da);
    int s_term;
    int d_term;
    int t;
    s_term = sc * factor_weight(c.src_factor, sc, sa, dc, da);
    d_term = dc * factor_weight(c.dst_factor, sc, sa, dc, da);
    case (c.equation)
      EQ_SUB:     t = s_term - d_term;
      EQ_REV_SUB: t = d_term - s_term;
      EQ_MIN:     t = (s_term < d_term) ? s_term : d_term;
      EQ_MAX:     t = (s_term > d_term) ? s_term : d_term;
      default:    t = s_term + d_term;
    endcase
    if (t < 0) t = 0;
    if (t > TERM_LIMIT) t = TERM_LIMIT;
    return CHAN_W'((t + HALF_STEP) / SCALE);
  endfunction

  // Alpha blends the alphas alone; color channels weigh in the alphas too
  function automatic rbu_pixel_t blend_pixel(rbu_cfg_t c, rbu_pixel_t s, rbu_pixel_t d);
    rbu_pixel_t p;
    p.red   = mix_channel(c, s.red,   s.alpha, d.red,   d.alpha);
    p.green = mix_channel(c, s.green, s.alpha, d.green, d.alpha);
    p.blue  = mix_channel(c, s.blue,  s.alpha, d.blue,  d.alpha);
    p.alpha = mix_channel(c, s.alpha, s.alpha, d.alpha, d.alpha);
    return p;
  endfunction

  // Lean toward the channel extremes so clamps and ties show up often
  function automatic blend_word_t random_word();
    blend_word_t w;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(7))
        0:       w[k*CHAN_W +: CHAN_W] = '0;
        1:       w[k*CHAN_W +: CHAN_W] = '1;
        default: w[k*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(255));
      endcase
    end
    return w;
  endfunction

  task automatic check_field(string name, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // APB write: setup then access; the register takes it at the access edge
  task automatic cfg_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SRC_FACTOR: blend_cfg.src_factor = value[FACT_W-1:0];
      REG_DST_FACTOR: blend_cfg.dst_factor = value[FACT_W-1:0];
      REG_EQUATION:   blend_cfg.equation   = value[EQ_W-1:0];
      default: ;
    endcase
  endtask

  // Queue the hand-picked pixel words
  task automatic load_directed();
    blend_word_t picks[8];
    picks[0] = 64'h00000000_00000000;
    picks[1] = 64'hFFFFFFFF_FFFFFFFF;
    picks[2] = 64'hFFFFFFFF_00000000;
    picks[3] = 64'h00000000_FFFFFFFF;
    picks[4] = 64'hAA55AA55_55AA55AA;
    picks[5] = 64'h55AA55AA_AA55AA55;
    picks[6] = 64'h8040C000_20E07FFF;
    picks[7] = 64'h7F01FEFF_80FE0100;
    foreach (picks[k]) pending_words.push_back(picks[k]);
  endtask

  // Wait until every queued word has gone through and its result came back
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || drv_valid || blended_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: hold a word until taken, then advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_word <= pending_words.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      sink_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Monitor: predict on each accepted word, check each accepted result
  always @(posedge clk) begin
    rbu_pixel_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      stuck_cycles <= 0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready)
        blended_pixels.push_back(blend_pixel(blend_cfg, drv_word.src, drv_word.dst));
      if (out_ch.valid && out_ch.ready) begin
        if (blended_pixels.size() == 0) begin
          $error("result word with no expectation pending");
          error_count++;
        end else begin
          want = blended_pixels.pop_front();
          check_field("out_red",   want.red,   out_ch.out_red);
          check_field("out_green", want.green, out_ch.out_green);
          check_field("out_blue",  want.blue,  out_ch.out_blue);
          check_field("out_alpha", want.alpha, out_ch.out_alpha);
        end
      end
      // Watchdog: end the simulation as failed if nothing moves for too long
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("rgba_blend_unit verification failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // Sequencer: reset, then one run per blend setting
  initial begin
    int r;
    logic [FACT_W-1:0] sf;
    logic [FACT_W-1:0] df;
    logic [EQ_W-1:0] eq;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < DIRECTED_RUNS + RANDOM_RUNS; p++) begin
      // Set up the blend while the block is idle
      if (p == 1 || p == 2) begin
        cfg_write(REG_SRC_FACTOR, {28'($urandom), FACT_ONE});
        cfg_write(REG_DST_FACTOR, {28'($urandom), FACT_ONE});
        cfg_write(REG_EQUATION, {29'($urandom), (p == 1) ? EQ_ADD : EQ_SUB});
      end else if (p >= DIRECTED_RUNS) begin
        r = p - DIRECTED_RUNS;
        sf = FACT_W'(r % 16);
        df = FACT_W'((r * 11 + 5) % 16);
        eq = EQ_W'(r % 8);
        cfg_write(REG_SRC_FACTOR, {28'($urandom), sf});
        cfg_write(REG_DST_FACTOR, {28'($urandom), df});
        cfg_write(REG_EQUATION, {29'($urandom), eq});
        cfg_write(REG_UNMAPPED, $urandom);
      end
      @(posedge clk);

      // Pick the idling pattern for this run
      case ((p < DIRECTED_RUNS) ? 0 : p % 4)
        1:       begin send_idle_pct = 87; sink_idle_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_idle_pct = 87; end
        3:       begin send_idle_pct = 15; sink_idle_pct = 15; end
        default: begin send_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase

      if (p < DIRECTED_RUNS)
        load_directed();
      else
        repeat (RANDOM_WORDS) pending_words.push_back(random_word());
      // Back up the block while the sender keeps offering
      if (p == HOLD_RUN) hold_toggle = ~hold_toggle;
      wait_drained();
    end

    if (error_count == 0) begin
      $display("rgba_blend_unit verification clean");
    end else begin
      $display("rgba_blend_unit verification failed");
    end
    $finish;
  end

endmodule
